// File: sv/assert_macros.svh
// Assertion helpers shared by the tracker modules.
// Each use expects clk_i and rst_ni in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define DRRT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent in one cycle implies the consequent in the next.
`define DRRT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/drrt_pkg.sv
package drrt_pkg;

  typedef enum logic [2:0] {
    KIND_TICK     = 3'd0,
    KIND_RX       = 3'd1,
    KIND_REQUEST  = 3'd2,
    KIND_ADD      = 3'd3,
    KIND_REMOVE   = 3'd4,
    KIND_SESSION  = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_NEG     = 2'd1,
    STATUS_PENDING = 2'd2,
    STATUS_NO_RESP = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    NOTIFY_NONE      = 2'd0,
    NOTIFY_REQUESTER = 2'd1,
    NOTIFY_LISTENER  = 2'd2
  } notify_e;

  typedef enum logic [1:0] {
    CFG_KEEPALIVE = 2'd0,
    CFG_P2        = 2'd1,
    CFG_P2_STAR   = 2'd2
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EXEC,
    ST_SHIFT,
    ST_OUT
  } state_e;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [7:0]  SID_NEG         = 8'h7F;
  localparam logic [7:0]  SID_TP          = 8'h3E;
  localparam logic [7:0]  NRC_PENDING     = 8'h78;
  localparam logic [7:0]  POS_OFFSET      = 8'h40;
  localparam logic [7:0]  SESSION_DEFAULT = 8'h01;

  localparam logic [15:0] KEEPALIVE_RST   = 16'd2000;
  localparam logic [15:0] P2_RST          = 16'd50;
  localparam logic [15:0] P2_STAR_RST     = 16'd5000;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic scan_step;
    logic exec;
    logic shift_step;
    logic shift_end;
    logic out_load;
  } drrt_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_done;
    logic remove_hit;
    logic shift_done;
  } drrt_sts_t;

  typedef struct packed {
    status_e    status;
    notify_e    notify;
    logic [2:0] lidx;
    logic       tp;
    logic       acc;
    logic [7:0] rsid;
  } drrt_res_t;

endpackage

// File: sv/drrt_ctrl.sv
`include "assert_macros.svh"

module drrt_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               out_stall_i,
  output logic               out_valid_o,
  input  drrt_pkg::drrt_sts_t sts_i,
  output drrt_pkg::drrt_cmd_t cmd_o
);
  import drrt_pkg::*;

  state_e    state_q, state_d;
  logic      out_valid_q, out_valid_d;
  drrt_cmd_t cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd        = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd.load = 1'b1;
          state_d  = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts_i.scan_done) begin
          state_d = ST_EXEC;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        state_d  = sts_i.remove_hit ? ST_SHIFT : ST_OUT;
      end
      ST_SHIFT: begin
        if (sts_i.shift_done) begin
          cmd.shift_end = 1'b1;
          state_d       = ST_OUT;
        end else begin
          cmd.shift_step = 1'b1;
        end
      end
      ST_OUT: begin
        // wait for the result slot to free up
        if (!out_valid_q || !out_stall_i) begin
          cmd.out_load = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_d = cmd.out_load | (out_valid_q & out_stall_i);
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

  `DRRT_ASSERT(a_no_overwrite, cmd.out_load |-> (!out_valid_q || !out_stall_i), "result overwritten")
  `DRRT_ASSERT_NEXT(a_load_scan, cmd.load, state_q == ST_SCAN, "load did not start scan")
  `DRRT_ASSERT(a_exec_after_scan, (state_q == ST_EXEC) |-> ($past(state_q) == ST_SCAN), "bad exec entry")

endmodule

// File: sv/drrt_dp.sv
`include "assert_macros.svh"

module drrt_dp #(
  parameter int unsigned MAX_LISTENERS = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  drrt_pkg::drrt_cmd_t                cmd_i,
  output drrt_pkg::drrt_sts_t                sts_o,
  input  logic                               cfg_we_i,
  input  logic [drrt_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [drrt_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  logic [2:0]                         kind_i,
  input  logic [7:0]                         req_sid_i,
  input  logic                               suppress_i,
  input  logic [7:0]                         rx_byte0_i,
  input  logic [7:0]                         rx_byte1_i,
  input  logic [7:0]                         rx_byte2_i,
  input  logic [7:0]                         session_type_i,
  input  logic [15:0]                        p2_value_i,
  input  logic [15:0]                        p2_star_value_i,
  output drrt_pkg::drrt_res_t                res_o
);
  import drrt_pkg::*;

  localparam int unsigned CNTW = $clog2(MAX_LISTENERS + 1);
  localparam int unsigned IDXW = (MAX_LISTENERS > 1) ? $clog2(MAX_LISTENERS) : 1;
  localparam logic [CNTW-1:0] MAX_CNT = CNTW'(MAX_LISTENERS);

  // configuration
  logic [15:0] ka_period_q, ka_period_d;
  logic [15:0] def_p2_q, def_p2_d;
  logic [15:0] def_p2s_q, def_p2s_d;

  // session state
  logic [31:0]     time_q, time_d;
  logic [7:0]      pend_q, pend_d;
  logic [31:0]     dl_q, dl_d;
  logic            sup_q, sup_d;
  logic [7:0]      session_q, session_d;
  logic [15:0]     p2_q, p2_d;
  logic [15:0]     p2s_q, p2s_d;
  logic [31:0]     ka_last_q, ka_last_d;
  logic            ka_sent_q, ka_sent_d;
  logic [CNTW-1:0] count_q, count_d;
  logic [CNTW-1:0] ptr_q, ptr_d;

  // captured request fields
  logic [2:0]  kind_q;
  logic [7:0]  req_q;
  logic        sup_in_q;
  logic [7:0]  b0_q, b1_q, b2_q;
  logic [7:0]  stype_q;
  logic [15:0] p2v_q, p2sv_q;

  logic [7:0] slots_q [MAX_LISTENERS];

  drrt_res_t res_q, res_d;
  drrt_res_t out_q;

  logic            neg;
  logic [7:0]      rx_sid;
  logic [7:0]      target;
  logic [CNTW-1:0] ptr_inc;
  logic [IDXW-1:0] rd_idx;
  logic [7:0]      rd_data;
  logic            in_range;
  logic            match;
  logic [31:0]     ka_diff;
  logic [31:0]     dl_diff;
  logic            ka_fire;
  logic            due;
  logic            pending;
  logic            add_wr;

  assign neg      = (b0_q == SID_NEG);
  assign rx_sid   = neg ? b1_q : (b0_q - POS_OFFSET);
  assign target   = (kind_q == KIND_REMOVE) ? req_q : rx_sid;
  assign ptr_inc  = ptr_q + 1'b1;
  // one read port: next slot while shifting, current slot while scanning
  assign rd_idx   = cmd_i.shift_step ? ptr_inc[IDXW-1:0] : ptr_q[IDXW-1:0];
  assign rd_data  = slots_q[rd_idx];
  assign in_range = (ptr_q != count_q);
  assign match    = in_range && (rd_data == target);

  assign ka_diff  = time_q - ka_last_q;
  assign dl_diff  = time_q - dl_q;
  assign ka_fire  = (session_q != SESSION_DEFAULT) &&
                    (!ka_sent_q || (ka_diff >= {16'h0000, ka_period_q}));
  assign due      = !dl_diff[31];
  assign pending  = (pend_q != 8'h00);
  assign add_wr   = cmd_i.exec && (kind_q == KIND_ADD) && (count_q < MAX_CNT);

  assign sts_o.scan_done  = !in_range || match;
  assign sts_o.remove_hit = (kind_q == KIND_REMOVE) && match;
  assign sts_o.shift_done = (ptr_inc >= count_q);

  always_comb begin
    ka_period_d = ka_period_q;
    def_p2_d    = def_p2_q;
    def_p2s_d   = def_p2s_q;
    time_d      = time_q;
    pend_d      = pend_q;
    dl_d        = dl_q;
    sup_d       = sup_q;
    session_d   = session_q;
    p2_d        = p2_q;
    p2s_d       = p2s_q;
    ka_last_d   = ka_last_q;
    ka_sent_d   = ka_sent_q;
    count_d     = count_q;
    ptr_d       = ptr_q;
    res_d       = res_q;

    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_KEEPALIVE: ka_period_d = cfg_wdata_i;
        CFG_P2:        def_p2_d    = cfg_wdata_i;
        CFG_P2_STAR:   def_p2s_d   = cfg_wdata_i;
        default: ;
      endcase
    end

    if (cmd_i.load) begin
      ptr_d = '0;
      if (kind_i == KIND_TICK) begin
        time_d = time_q + 32'd1;
      end
    end

    if (cmd_i.scan_step || cmd_i.shift_step) begin
      ptr_d = ptr_inc;
    end

    if (cmd_i.shift_end) begin
      count_d = count_q - 1'b1;
    end

    if (cmd_i.exec) begin
      res_d = '0;
      unique case (kind_q)
        KIND_TICK: begin
          res_d.tp = ka_fire;
          if (ka_fire) begin
            ka_last_d = time_q;
            ka_sent_d = 1'b1;
          end
          if (pending) begin
            if (!sup_q) res_d.status = STATUS_PENDING;
            if (due) begin
              res_d.status = sup_q ? STATUS_OK : STATUS_NO_RESP;
              res_d.notify = NOTIFY_REQUESTER;
              res_d.rsid   = pend_q;
              pend_d       = 8'h00;
            end
          end
        end
        KIND_RX: begin
          res_d.tp = ka_fire;
          if (ka_fire) begin
            ka_last_d = time_q;
            ka_sent_d = 1'b1;
          end
          res_d.status = neg ? STATUS_NEG : STATUS_OK;
          res_d.rsid   = rx_sid;
          if (pending && (pend_q == rx_sid)) begin
            if (neg && (b2_q == NRC_PENDING)) begin
              res_d.status = STATUS_PENDING;
              dl_d         = time_q + 32'(p2s_q);
            end else begin
              res_d.notify = NOTIFY_REQUESTER;
              pend_d       = 8'h00;
            end
          end else if (rx_sid == SID_TP) begin
            // tester present reply: session fell back to default
            session_d = SESSION_DEFAULT;
            p2_d      = def_p2_q;
            p2s_d     = def_p2s_q;
          end else if (match) begin
            res_d.notify = NOTIFY_LISTENER;
            res_d.lidx   = 3'(ptr_q);
          end
        end
        KIND_REQUEST: begin
          res_d.rsid = req_q;
          if (!pending && (req_q != 8'h00)) begin
            sup_d     = sup_in_q;
            pend_d    = req_q;
            dl_d      = time_q + 32'(p2_q);
            res_d.acc = 1'b1;
          end
        end
        KIND_ADD: begin
          res_d.rsid = req_q;
          if (count_q < MAX_CNT) begin
            count_d   = count_q + 1'b1;
            res_d.acc = 1'b1;
          end
        end
        KIND_REMOVE: begin
          res_d.rsid = req_q;
          res_d.acc  = match;
        end
        KIND_SESSION: begin
          if (stype_q != 8'h00) session_d = stype_q;
          p2_d      = p2v_q;
          p2s_d     = p2sv_q;
          res_d.acc = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ka_period_q <= KEEPALIVE_RST;
      def_p2_q    <= P2_RST;
      def_p2s_q   <= P2_STAR_RST;
      time_q      <= '0;
      pend_q      <= '0;
      dl_q        <= '0;
      sup_q       <= 1'b0;
      session_q   <= SESSION_DEFAULT;
      p2_q        <= P2_RST;
      p2s_q       <= P2_STAR_RST;
      ka_last_q   <= '0;
      ka_sent_q   <= 1'b0;
      count_q     <= '0;
      ptr_q       <= '0;
    end else begin
      ka_period_q <= ka_period_d;
      def_p2_q    <= def_p2_d;
      def_p2s_q   <= def_p2s_d;
      time_q      <= time_d;
      pend_q      <= pend_d;
      dl_q        <= dl_d;
      sup_q       <= sup_d;
      session_q   <= session_d;
      p2_q        <= p2_d;
      p2s_q       <= p2s_d;
      ka_last_q   <= ka_last_d;
      ka_sent_q   <= ka_sent_d;
      count_q     <= count_d;
      ptr_q       <= ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q   <= kind_i;
      req_q    <= req_sid_i;
      sup_in_q <= suppress_i;
      b0_q     <= rx_byte0_i;
      b1_q     <= rx_byte1_i;
      b2_q     <= rx_byte2_i;
      stype_q  <= session_type_i;
      p2v_q    <= p2_value_i;
      p2sv_q   <= p2_star_value_i;
    end
    res_q <= res_d;
    if (cmd_i.out_load) begin
      out_q <= res_q;
    end
  end

  // listener table: removal moves later entries down one per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.shift_step) begin
      slots_q[ptr_q[IDXW-1:0]] <= rd_data;
    end else if (add_wr) begin
      slots_q[count_q[IDXW-1:0]] <= req_q;
    end
  end

  assign res_o = out_q;

  `DRRT_ASSERT(a_count_max, count_q <= MAX_CNT, "listener count overflow")
  `DRRT_ASSERT(a_shift_range, cmd_i.shift_step |-> (ptr_inc < count_q), "shift beyond table")

endmodule

// File: sv/diag_request_response_tracker_unit.sv
// Diagnostic client tracker: tracks one pending request against its P2/P2*
// deadline, matches positive, negative and response-pending replies, looks up
// unsolicited replies in a listener table of MAX_LISTENERS entries and flags
// tester-present messages outside the default session. Every accepted request
// yields exactly one result. An item passes the idle, scan, exec and output
// states; the scan runs over listener slots until a hit or the fill count,
// and a successful removal adds a shift state that moves each later entry
// down one. The listener table is scanned one slot per cycle through a single
// read port. A new request is taken only in idle, after the previous result
// has been loaded into the output, which waits while out_stall_i holds an
// earlier result. Configuration writes take effect at once and belong in
// idle time only.
module diag_request_response_tracker_unit #(
  parameter int unsigned MAX_LISTENERS = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [drrt_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [drrt_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [2:0]                      kind_i,
  input  logic [7:0]                      req_sid_i,
  input  logic                            suppress_i,
  input  logic [7:0]                      rx_byte0_i,
  input  logic [7:0]                      rx_byte1_i,
  input  logic [7:0]                      rx_byte2_i,
  input  logic [7:0]                      session_type_i,
  input  logic [15:0]                     p2_value_i,
  input  logic [15:0]                     p2_star_value_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [1:0]                      status_o,
  output logic [1:0]                      notify_o,
  output logic [2:0]                      listener_index_o,
  output logic                            send_tester_present_o,
  output logic                            accepted_o,
  output logic [7:0]                      result_sid_o
);
  import drrt_pkg::*;

  drrt_cmd_t cmd;
  drrt_sts_t sts;
  drrt_res_t res;

  drrt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  drrt_dp #(
    .MAX_LISTENERS (MAX_LISTENERS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .kind_i          (kind_i),
    .req_sid_i       (req_sid_i),
    .suppress_i      (suppress_i),
    .rx_byte0_i      (rx_byte0_i),
    .rx_byte1_i      (rx_byte1_i),
    .rx_byte2_i      (rx_byte2_i),
    .session_type_i  (session_type_i),
    .p2_value_i      (p2_value_i),
    .p2_star_value_i (p2_star_value_i),
    .res_o           (res)
  );

  assign status_o              = res.status;
  assign notify_o              = res.notify;
  assign listener_index_o      = res.lidx;
  assign send_tester_present_o = res.tp;
  assign accepted_o            = res.acc;
  assign result_sid_o          = res.rsid;

endmodule
